// ----- hdl/lqe_pkg.sv -----
package lqe_pkg;

    // Pipeline depths of the shared units.
    localparam int SCALE_LAT   = 4;
    localparam int CROSS_LAT   = 2;
    localparam int ISQRT_STEPS = 32;
    localparam int ISQRT_TOP   = 2 * ISQRT_STEPS - 2;
    localparam int DIV_STEPS   = 32;
    localparam int PROJ_LAT    = 5 + ISQRT_STEPS + DIV_STEPS;

    // Stage numbers, counted from the input register, where results appear.
    localparam int T_D   = SCALE_LAT;
    localparam int T_C   = T_D + CROSS_LAT + SCALE_LAT;
    localparam int T_N   = T_C + CROSS_LAT + SCALE_LAT;
    localparam int T_END = T_N + PROJ_LAT;
    localparam int DLY6  = CROSS_LAT + SCALE_LAT;

    localparam int NORMAL_FRAC_BITS = 14;

    localparam logic [1:0] CFG_EYE_X = 2'd0;
    localparam logic [1:0] CFG_EYE_Y = 2'd1;
    localparam logic [1:0] CFG_EYE_Z = 2'd2;

    localparam logic [2:0] VTX_LAST = 3'd5;

    typedef logic [2:0][31:0] t_vec32;
    typedef logic [2:0][63:0] t_vec64;

    typedef struct packed {
        t_vec32      a;
        t_vec32      b;
        logic [30:0] width;
        logic [31:0] color;
    } t_line;

    typedef struct packed {
        logic use_b;
        logic neg;
    } t_vtx_sel;

    // Vertex order of the quad: A-side, A+side, B+side, A-side, B+side, B-side.
    function automatic t_vtx_sel vtx_sel(input logic [2:0] idx);
        t_vtx_sel s;
        case (idx)
            3'd0:    s = '{use_b: 1'b0, neg: 1'b1};
            3'd1:    s = '{use_b: 1'b0, neg: 1'b0};
            3'd2:    s = '{use_b: 1'b1, neg: 1'b0};
            3'd3:    s = '{use_b: 1'b0, neg: 1'b1};
            3'd4:    s = '{use_b: 1'b1, neg: 1'b0};
            3'd5:    s = '{use_b: 1'b1, neg: 1'b1};
            default: s = '{use_b: 1'b0, neg: 1'b0};
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/lqe_scale.sv -----
module lqe_scale import lqe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_vec64 i_vec,
    output t_vec32 o_vec,
    output logic   o_nz
);
    localparam logic [5:0] POS_HI = 6'd30;
    localparam logic [5:0] POS_LO = 6'd29;

    t_vec64      r1_mag, n1_mag;
    logic [2:0]  r1_sgn, n1_sgn;
    logic [63:0] r1_max, n1_max;

    t_vec64      r2_mag;
    logic [2:0]  r2_sgn;
    logic [63:0] r2_max;
    logic [5:0]  r2_pos, n2_pos;
    logic        r2_nz;

    t_vec64      r3_mag;
    logic [2:0]  r3_sgn;
    logic        r3_nz, r3_right, n3_right;
    logic [5:0]  r3_sh, n3_sh;

    t_vec32      r4_vec, n4_vec;
    logic        r4_nz;

    always_comb begin
        n1_max = '0;
        for (int i = 0; i < 3; i++) begin
            n1_sgn[i] = i_vec[i][63];
            n1_mag[i] = i_vec[i][63] ? (64'd0 - i_vec[i]) : i_vec[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (n1_mag[i] > n1_max) begin
                n1_max = n1_mag[i];
            end
        end
    end

    always_comb begin
        n2_pos = '0;
        for (int i = 0; i < 64; i++) begin
            if (r1_max[i]) begin
                n2_pos = 6'(i);
            end
        end
    end

    // Largest magnitude goes to [2^29, 2^30]; a right shift stops early when
    // the top part lands exactly on 2^30.
    always_comb begin
        logic [63:0] t;
        t = r2_max >> (r2_pos - POS_HI);
        if (r2_pos >= POS_HI) begin
            n3_right = 1'b1;
            n3_sh    = (t == (64'd1 << POS_HI)) ? (r2_pos - POS_HI) : (r2_pos - POS_LO);
        end else begin
            n3_right = 1'b0;
            n3_sh    = POS_LO - r2_pos;
        end
    end

    always_comb begin
        logic [63:0] m;
        for (int i = 0; i < 3; i++) begin
            m         = r3_right ? (r3_mag[i] >> r3_sh) : (r3_mag[i] << r3_sh);
            n4_vec[i] = r3_sgn[i] ? (32'd0 - {1'b0, m[30:0]}) : {1'b0, m[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag   <= n1_mag;
            r1_sgn   <= n1_sgn;
            r1_max   <= n1_max;
            r2_mag   <= r1_mag;
            r2_sgn   <= r1_sgn;
            r2_max   <= r1_max;
            r2_pos   <= n2_pos;
            r2_nz    <= (r1_max != 64'd0);
            r3_mag   <= r2_mag;
            r3_sgn   <= r2_sgn;
            r3_nz    <= r2_nz;
            r3_right <= n3_right;
            r3_sh    <= n3_sh;
            r4_vec   <= n4_vec;
            r4_nz    <= r3_nz;
        end
    end

    assign o_vec = r4_vec;
    assign o_nz  = r4_nz;
endmodule

// ----- hdl/lqe_cross.sv -----
module lqe_cross import lqe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_vec32 i_p,
    input  t_vec32 i_q,
    output t_vec64 o_r
);
    logic signed [31:0] p0, p1, p2, q0, q1, q2;
    logic signed [63:0] n_pr [0:5];
    logic signed [63:0] r_pr [0:5];
    t_vec64             r_r;

    assign p0 = i_p[0];
    assign p1 = i_p[1];
    assign p2 = i_p[2];
    assign q0 = i_q[0];
    assign q1 = i_q[1];
    assign q2 = i_q[2];

    always_comb begin
        n_pr[0] = p1 * q2;
        n_pr[1] = p2 * q1;
        n_pr[2] = p2 * q0;
        n_pr[3] = p0 * q2;
        n_pr[4] = p0 * q1;
        n_pr[5] = p1 * q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_pr[k] <= n_pr[k];
            end
            r_r[0] <= r_pr[0] - r_pr[1];
            r_r[1] <= r_pr[2] - r_pr[3];
            r_r[2] <= r_pr[4] - r_pr[5];
        end
    end

    assign o_r = r_r;
endmodule

// ----- hdl/lqe_isqrt.sv -----
module lqe_isqrt import lqe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    output logic [31:0] o_root
);
    logic [63:0] r_x [0:ISQRT_STEPS-1];
    logic [63:0] r_r [0:ISQRT_STEPS-1];
    logic [63:0] n_x [0:ISQRT_STEPS-1];
    logic [63:0] n_r [0:ISQRT_STEPS-1];

    // One result bit per stage, trial bit walking down by two places.
    always_comb begin
        logic [63:0] px, pr, sqbit, t;
        for (int k = 0; k < ISQRT_STEPS; k++) begin
            px    = (k == 0) ? i_x : r_x[(k == 0) ? 0 : k - 1];
            pr    = (k == 0) ? 64'd0 : r_r[(k == 0) ? 0 : k - 1];
            sqbit = 64'd1 << (ISQRT_TOP - 2 * k);
            t     = pr + sqbit;
            if (px >= t) begin
                n_x[k] = px - t;
                n_r[k] = (pr >> 1) + sqbit;
            end else begin
                n_x[k] = px;
                n_r[k] = pr >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ISQRT_STEPS; k++) begin
                r_x[k] <= n_x[k];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_root = r_r[ISQRT_STEPS-1][31:0];
endmodule

// ----- hdl/lqe_div.sv -----
module lqe_div import lqe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_vec64      i_num,
    input  logic [31:0] i_den,
    output t_vec32      o_q
);
    logic [63:0] r_rem [0:2][0:DIV_STEPS-1];
    logic [31:0] r_q   [0:2][0:DIV_STEPS-1];
    logic [31:0] r_den [0:DIV_STEPS-1];
    logic [63:0] n_rem [0:2][0:DIV_STEPS-1];
    logic [31:0] n_q   [0:2][0:DIV_STEPS-1];
    logic [31:0] n_den [0:DIV_STEPS-1];

    // Restoring division, one quotient bit per stage from the top down.
    always_comb begin
        logic [63:0] prem, sub;
        logic [31:0] pq, pden;
        for (int k = 0; k < DIV_STEPS; k++) begin
            pden     = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            n_den[k] = pden;
            sub      = {32'd0, pden} << (DIV_STEPS - 1 - k);
            for (int l = 0; l < 3; l++) begin
                prem = (k == 0) ? i_num[l] : r_rem[l][(k == 0) ? 0 : k - 1];
                pq   = (k == 0) ? 32'd0 : r_q[l][(k == 0) ? 0 : k - 1];
                if (prem >= sub) begin
                    n_rem[l][k] = prem - sub;
                    n_q[l][k]   = pq | (32'd1 << (DIV_STEPS - 1 - k));
                end else begin
                    n_rem[l][k] = prem;
                    n_q[l][k]   = pq;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_den[k] <= n_den[k];
                for (int l = 0; l < 3; l++) begin
                    r_rem[l][k] <= n_rem[l][k];
                    r_q[l][k]   <= n_q[l][k];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_q[l] = r_q[l][DIV_STEPS-1];
        end
    end
endmodule

// ----- hdl/lqe_project.sv -----
module lqe_project import lqe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_vec32      i_vec,
    input  logic [30:0] i_mul,
    input  logic        i_dbl,
    output t_vec32      o_q
);
    // Computes round(vec_i * mul / den) with den = 2*|vec| when dbl is set,
    // |vec| otherwise.
    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       sgn;
        logic [30:0]      mul;
        logic             dbl;
    } t_pas;

    t_pas             n1_pas, r1_pas, r2_pas;
    logic [2:0][61:0] n1_sq, r1_sq;
    logic [63:0]      r2_sum;
    t_pas             r_pd [0:ISQRT_STEPS-1];
    logic [31:0]      root;
    logic [2:0][61:0] r5_prod;
    logic [31:0]      r5_len;
    logic [2:0]       r5_sgn;
    logic             r5_dbl;
    t_vec64           r6_num, n6_num;
    logic [31:0]      r6_den;
    logic [2:0]       r6_sgn;
    logic [2:0]       r_sd [0:DIV_STEPS-1];
    t_vec32           quo;
    t_vec32           r7_q, n7_q;

    always_comb begin
        logic [31:0] m;
        for (int i = 0; i < 3; i++) begin
            m             = i_vec[i][31] ? (32'd0 - i_vec[i]) : i_vec[i];
            n1_pas.mag[i] = m[30:0];
            n1_pas.sgn[i] = i_vec[i][31];
            n1_sq[i]      = n1_pas.mag[i] * n1_pas.mag[i];
        end
        n1_pas.mul = i_mul;
        n1_pas.dbl = i_dbl;
    end

    lqe_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_x    (r2_sum),
        .o_root (root)
    );

    always_comb begin
        logic [31:0] half;
        half = r5_dbl ? r5_len : (r5_len >> 1);
        for (int i = 0; i < 3; i++) begin
            n6_num[i] = {2'b00, r5_prod[i]} + {32'd0, half};
        end
    end

    lqe_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r6_num),
        .i_den (r6_den),
        .o_q   (quo)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_q[i] = r_sd[DIV_STEPS-1][i] ? (32'd0 - quo[i]) : quo[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pas <= n1_pas;
            r1_sq  <= n1_sq;
            r2_pas <= r1_pas;
            r2_sum <= {2'b00, r1_sq[0]} + {2'b00, r1_sq[1]} + {2'b00, r1_sq[2]};
            r_pd[0] <= r2_pas;
            for (int k = 1; k < ISQRT_STEPS; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r5_prod[i] <= r_pd[ISQRT_STEPS-1].mag[i] * r_pd[ISQRT_STEPS-1].mul;
            end
            r5_len <= root;
            r5_sgn <= r_pd[ISQRT_STEPS-1].sgn;
            r5_dbl <= r_pd[ISQRT_STEPS-1].dbl;
            r6_num <= n6_num;
            r6_den <= r5_dbl ? {r5_len[30:0], 1'b0} : r5_len;
            r6_sgn <= r5_sgn;
            r_sd[0] <= r6_sgn;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r7_q <= n7_q;
        end
    end

    assign o_q = r7_q;
endmodule

// ----- hdl/line_to_quad_expander.sv -----
// The vertex emitter hands out the six vertices of a quad at one per cycle while
// i_ready is high, and the pipeline behind it moves whenever its last stage is
// empty or can be handed to the emitter, so new lines are taken in while a quad
// is still being emitted until that last stage is full.
// Reset (synchronous, active low) empties the pipeline and the emitter and sets
// the eye position to zero.
module line_to_quad_expander import lqe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_point_a_x,
    input  logic [31:0] i_point_a_y,
    input  logic [31:0] i_point_a_z,
    input  logic [31:0] i_point_b_x,
    input  logic [31:0] i_point_b_y,
    input  logic [31:0] i_point_b_z,
    input  logic [30:0] i_line_width,
    input  logic [31:0] i_line_color,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pos_x,
    output logic [31:0] o_pos_y,
    output logic [31:0] o_pos_z,
    output logic [15:0] o_norm_x,
    output logic [15:0] o_norm_y,
    output logic [15:0] o_norm_z,
    output logic [31:0] o_vertex_color,
    output logic [2:0]  o_vertex_index,
    output logic        o_last_vertex
);
    t_vec32      r_eye;
    logic        r_vld  [0:T_END];
    t_line       r_line [0:T_END];
    t_line       n_line;
    t_vec32      r_ds   [0:DLY6-1];
    t_vec32      r_cs   [0:DLY6-1];
    logic        r_cnz  [0:T_END-T_C-1];
    logic        r_nnz  [0:PROJ_LAT-1];

    logic        adv, em_load;
    t_vec64      d_raw, v_raw, c_raw, n_raw;
    t_vec32      d_s, v_s, c_s, n_s, q_side, q_nrm;
    logic        d_nz, v_nz, c_nz, n_nz;

    t_vec32      side_end;
    logic [2:0][15:0] nrm_end;
    logic        any_side;

    logic        r_em_vld;
    logic [2:0]  r_cnt;
    t_vec32      r_em_a, r_em_b, r_em_side;
    logic [2:0][15:0] r_em_nrm;
    logic [31:0] r_em_col;
    t_vtx_sel    sel;
    t_vec32      pos;

    function automatic logic [15:0] sat16(input logic [31:0] q);
        logic signed [31:0] s;
        s = q;
        if (s > 32'sd32767) begin
            return 16'h7FFF;
        end else if (s < -32'sd32768) begin
            return 16'h8000;
        end
        return q[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EYE_X: r_eye[0] <= i_cfg_data;
                CFG_EYE_Y: r_eye[1] <= i_cfg_data;
                CFG_EYE_Z: r_eye[2] <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign em_load = r_vld[T_END] && (!r_em_vld || (i_ready && r_cnt == VTX_LAST));
    assign adv     = !r_vld[T_END] || em_load;
    assign o_ready = adv;

    always_comb begin
        n_line.a     = {i_point_a_z, i_point_a_y, i_point_a_x};
        n_line.b     = {i_point_b_z, i_point_b_y, i_point_b_x};
        n_line.width = i_line_width;
        n_line.color = i_line_color;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_raw[i] = {{32{r_line[0].b[i][31]}}, r_line[0].b[i]}
                     - {{32{r_line[0].a[i][31]}}, r_line[0].a[i]};
            v_raw[i] = {{32{r_line[0].b[i][31]}}, r_line[0].b[i]}
                     - {{32{r_eye[i][31]}}, r_eye[i]};
        end
    end

    lqe_scale u_scale_d (.i_clk(i_clk), .i_en(adv), .i_vec(d_raw), .o_vec(d_s), .o_nz(d_nz));
    lqe_scale u_scale_v (.i_clk(i_clk), .i_en(adv), .i_vec(v_raw), .o_vec(v_s), .o_nz(v_nz));

    lqe_cross u_cross_c (.i_clk(i_clk), .i_en(adv), .i_p(d_s), .i_q(v_s), .o_r(c_raw));
    lqe_scale u_scale_c (.i_clk(i_clk), .i_en(adv), .i_vec(c_raw), .o_vec(c_s), .o_nz(c_nz));

    lqe_cross u_cross_n (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_p   (r_ds[DLY6-1]),
        .i_q   (c_s),
        .o_r   (n_raw)
    );
    lqe_scale u_scale_n (.i_clk(i_clk), .i_en(adv), .i_vec(n_raw), .o_vec(n_s), .o_nz(n_nz));

    lqe_project u_proj_side (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_vec (r_cs[DLY6-1]),
        .i_mul (r_line[T_N].width),
        .i_dbl (1'b1),
        .o_q   (q_side)
    );

    lqe_project u_proj_nrm (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_vec (n_s),
        .i_mul (31'd1 << NORMAL_FRAC_BITS),
        .i_dbl (1'b0),
        .o_q   (q_nrm)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_line[0] <= n_line;
            for (int k = 1; k <= T_END; k++) begin
                r_line[k] <= r_line[k-1];
            end
            r_ds[0] <= d_s;
            r_cs[0] <= c_s;
            for (int k = 1; k < DLY6; k++) begin
                r_ds[k] <= r_ds[k-1];
                r_cs[k] <= r_cs[k-1];
            end
            r_cnz[0] <= c_nz;
            for (int k = 1; k < T_END - T_C; k++) begin
                r_cnz[k] <= r_cnz[k-1];
            end
            r_nnz[0] <= n_nz;
            for (int k = 1; k < PROJ_LAT; k++) begin
                r_nnz[k] <= r_nnz[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= T_END; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= T_END; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // A zero cross product leaves the divider without a length, so its
    // result is dropped; the normal needs a nonzero side as well.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            side_end[i] = r_cnz[T_END-T_C-1] ? q_side[i] : 32'd0;
        end
        any_side = (side_end[0] != 32'd0) || (side_end[1] != 32'd0)
                || (side_end[2] != 32'd0);
        for (int i = 0; i < 3; i++) begin
            nrm_end[i] = (any_side && r_nnz[PROJ_LAT-1]) ? sat16(q_nrm[i]) : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_vld <= 1'b0;
            r_cnt    <= '0;
        end else if (em_load) begin
            r_em_vld <= 1'b1;
            r_cnt    <= '0;
        end else if (r_em_vld && i_ready) begin
            if (r_cnt == VTX_LAST) begin
                r_em_vld <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_load) begin
            r_em_a    <= r_line[T_END].a;
            r_em_b    <= r_line[T_END].b;
            r_em_col  <= r_line[T_END].color;
            r_em_side <= side_end;
            r_em_nrm  <= nrm_end;
        end
    end

    always_comb begin
        logic [31:0] p;
        sel = vtx_sel(r_cnt);
        for (int i = 0; i < 3; i++) begin
            p      = sel.use_b ? r_em_b[i] : r_em_a[i];
            pos[i] = sel.neg ? (p - r_em_side[i]) : (p + r_em_side[i]);
        end
    end

    assign o_valid        = r_em_vld;
    assign o_pos_x        = pos[0];
    assign o_pos_y        = pos[1];
    assign o_pos_z        = pos[2];
    assign o_norm_x       = r_em_nrm[0];
    assign o_norm_y       = r_em_nrm[1];
    assign o_norm_z       = r_em_nrm[2];
    assign o_vertex_color = r_em_col;
    assign o_vertex_index = r_cnt;
    assign o_last_vertex  = (r_cnt == VTX_LAST);

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_vld |-> (r_cnt <= VTX_LAST))
        else $error("vertex counter past the last vertex");

    a_no_load_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !em_load)
        else $error("emitter reloaded while a vertex waits");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[T_END] && !em_load) |-> !o_ready)
        else $error("input taken while the pipeline is blocked");

    a_quad_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && r_cnt == VTX_LAST && !em_load) |=> !o_valid)
        else $error("emitter stays valid after the last vertex");
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import lqe_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 5000;

    typedef longint t_vec3[3];

    typedef struct {
        logic [31:0] a[3];
        logic [31:0] b[3];
        logic [30:0] width;
        logic [31:0] color;
    } t_seg;

    typedef struct {
        logic [31:0] pos[3];
        logic [15:0] norm[3];
        logic [31:0] color;
        logic [2:0]  idx;
        logic        last;
    } t_vertex;

    class quad_scoreboard;
        longint  eye[3];
        t_vertex pending[$];
        int      errors;

        function new();
            eye = '{0, 0, 0};
            errors = 0;
        endfunction

        function void set_eye(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_EYE_X) eye[0] = longint'($signed(val));
            else if (idx == CFG_EYE_Y) eye[1] = longint'($signed(val));
            else if (idx == CFG_EYE_Z) eye[2] = longint'($signed(val));
        endfunction

        function longint unsigned absu(longint x);
            return x < 0 ? longint'(-x) : longint'(x);
        endfunction

        // Brings the largest magnitude into [2^29, 2^30]; shifts truncate toward zero.
        function bit normalize(inout t_vec3 v);
            longint unsigned m, a;
            int s;
            m = 0;
            for (int i = 0; i < 3; i++) if (absu(v[i]) > m) m = absu(v[i]);
            if (m == 0) return 0;
            if (m > (64'd1 << 30)) begin
                s = 0;
                while ((m >> s) > (64'd1 << 30)) s++;
                for (int i = 0; i < 3; i++) begin
                    a = absu(v[i]) >> s;
                    v[i] = v[i] < 0 ? -longint'(a) : longint'(a);
                end
            end else begin
                while (m < (64'd1 << 29)) begin
                    for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
                    m = m << 1;
                end
            end
            return 1;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned r, bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > x) bt = bt >> 2;
            while (bt != 0) begin
                if (x >= r + bt) begin
                    x = x - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
            return r;
        endfunction

        function longint round_div(longint num, longint unsigned den);
            longint unsigned q;
            q = (absu(num) + den / 2) / den;
            return num < 0 ? -longint'(q) : longint'(q);
        endfunction

        function t_vec3 cross3(t_vec3 p, t_vec3 q);
            t_vec3 r;
            r[0] = p[1] * q[2] - p[2] * q[1];
            r[1] = p[2] * q[0] - p[0] * q[2];
            r[2] = p[0] * q[1] - p[1] * q[0];
            return r;
        endfunction

        function longint unsigned length3(t_vec3 v);
            return floor_sqrt(longint'(v[0] * v[0]) + longint'(v[1] * v[1])
                              + longint'(v[2] * v[2]));
        endfunction

        function void note_line(t_seg s);
            t_vec3 a, b, d, v, c, n;
            longint side[3], nrm[3], q;
            longint unsigned len;
            bit any;
            t_vertex vx;
            side = '{0, 0, 0};
            nrm = '{0, 0, 0};
            for (int i = 0; i < 3; i++) begin
                a[i] = longint'($signed(s.a[i]));
                b[i] = longint'($signed(s.b[i]));
                d[i] = b[i] - a[i];
                v[i] = b[i] - eye[i];
            end
            if (normalize(d) && normalize(v)) begin
                c = cross3(d, v);
                if (normalize(c)) begin
                    len = length3(c);
                    any = 0;
                    for (int i = 0; i < 3; i++) begin
                        side[i] = round_div(c[i] * longint'(s.width), 2 * len);
                        if (side[i] != 0) any = 1;
                    end
                    if (any) begin
                        n = cross3(d, c);
                        if (normalize(n)) begin
                            len = length3(n);
                            for (int i = 0; i < 3; i++) begin
                                q = round_div(n[i] * (64'sd1 <<< NORMAL_FRAC_BITS), len);
                                if (q > 32767) q = 32767;
                                if (q < -32768) q = -32768;
                                nrm[i] = q;
                            end
                        end
                    end
                end
            end
            for (int k = 0; k < 6; k++) begin
                for (int i = 0; i < 3; i++) begin
                    q = (k == 2 || k == 4 || k == 5) ? b[i] : a[i];
                    q = (k == 0 || k == 3 || k == 5) ? q - side[i] : q + side[i];
                    vx.pos[i] = q[31:0];
                    vx.norm[i] = nrm[i][15:0];
                end
                vx.color = s.color;
                vx.idx = 3'(k);
                vx.last = (3'(k) == VTX_LAST);
                pending.push_back(vx);
            end
        endfunction

        function void compare(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                $error("%s: expected %h, got %h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_vertex(t_vertex got);
            t_vertex exp;
            if (pending.size() == 0) begin
                $error("vertex with no pending expectation (index %0d)", got.idx);
                errors++;
                return;
            end
            exp = pending.pop_front();
            compare("pos_x", exp.pos[0], got.pos[0]);
            compare("pos_y", exp.pos[1], got.pos[1]);
            compare("pos_z", exp.pos[2], got.pos[2]);
            compare("norm_x", exp.norm[0], got.norm[0]);
            compare("norm_y", exp.norm[1], got.norm[1]);
            compare("norm_z", exp.norm[2], got.norm[2]);
            compare("vertex_color", exp.color, got.color);
            compare("vertex_index", exp.idx, got.idx);
            compare("last_vertex", exp.last, got.last);
        endfunction

        function bit empty();
            return pending.size() == 0;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_point_a_x, i_point_a_y, i_point_a_z;
    logic [31:0] i_point_b_x, i_point_b_y, i_point_b_z;
    logic [30:0] i_line_width;
    logic [31:0] i_line_color;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic [15:0] o_norm_x, o_norm_y, o_norm_z;
    logic [31:0] o_vertex_color;
    logic [2:0]  o_vertex_index;
    logic        o_last_vertex;

    quad_scoreboard quads = new();
    bit calm;
    bit hold_request;
    int quiet_cycles = 0;

    line_to_quad_expander dut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        t_seg s;
        t_vertex vx;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                s.a = '{i_point_a_x, i_point_a_y, i_point_a_z};
                s.b = '{i_point_b_x, i_point_b_y, i_point_b_z};
                s.width = i_line_width;
                s.color = i_line_color;
                quads.note_line(s);
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                vx.pos = '{o_pos_x, o_pos_y, o_pos_z};
                vx.norm = '{o_norm_x, o_norm_y, o_norm_z};
                vx.color = o_vertex_color;
                vx.idx = o_vertex_index;
                vx.last = o_last_vertex;
                quads.check_vertex(vx);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Receiver side: random stalls, one long hold-off on request, none when calm.
    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (calm) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else if (hold_request) begin
                i_ready <= 1'b0;
                repeat (1000) @(posedge i_clk);
                hold_request = 0;
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        quads.set_eye(idx, val);
        @(posedge i_clk);
    endtask

    // Writes all three eye registers, plus one write to the unused index.
    task automatic place_eye(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        write_reg(CFG_EYE_X, x);
        write_reg(CFG_EYE_Y, y);
        write_reg(CFG_UNUSED, $urandom());
        write_reg(CFG_EYE_Z, z);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_line(t_seg s);
        i_valid <= 1'b1;
        i_point_a_x <= s.a[0];
        i_point_a_y <= s.a[1];
        i_point_a_z <= s.a[2];
        i_point_b_x <= s.b[0];
        i_point_b_y <= s.b[1];
        i_point_b_z <= s.b[2];
        i_line_width <= s.width;
        i_line_color <= s.color;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pause_sender(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (!quads.empty()) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_seg make_seg(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                      logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                      logic [30:0] w, logic [31:0] col);
        t_seg s;
        s.a = '{ax, ay, az};
        s.b = '{bx, by, bz};
        s.width = w;
        s.color = col;
        return s;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
            default: return 32'($signed($urandom_range(0, 400000)) - 200000) <<
                            $urandom_range(0, 8);
        endcase
    endfunction

    function automatic t_seg rand_seg();
        t_seg s;
        for (int i = 0; i < 3; i++) begin
            s.a[i] = rand_coord();
            s.b[i] = $urandom_range(0, 9) == 0 ? s.a[i] : rand_coord();
        end
        case ($urandom_range(0, 9))
            0:       s.width = '0;
            1:       s.width = 31'($urandom_range(0, 7));
            2, 3:    s.width = 31'($urandom());
            default: s.width = 31'($urandom_range(1, 20 << 16));
        endcase
        s.color = $urandom();
        return s;
    endfunction

    task automatic random_lines(int count);
        for (int i = 0; i < count; i++) begin
            send_line(rand_seg());
            if (!calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 19));
        end
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] SMIN = 32'h8000_0000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_EYE_X;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_point_a_x <= '0;
        i_point_a_y <= '0;
        i_point_a_z <= '0;
        i_point_b_x <= '0;
        i_point_b_y <= '0;
        i_point_b_z <= '0;
        i_line_width <= '0;
        i_line_color <= '0;
        calm = 0;
        hold_request = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines with the eye at its reset position.
        send_line(make_seg(0, 0, 0, 0, 0, 0, 31'(ONE), 32'hFFFF_FFFF));  // zero length
        send_line(make_seg(ONE, ONE, 0, 0, 0, 0, 31'(ONE), '0));         // B at the eye
        send_line(make_seg(ONE, 0, 0, 2 * ONE, 0, 0, 31'(ONE), 1));      // eye on the line
        send_line(make_seg(ONE, 0, 5 * ONE, ONE, 3 * ONE, 5 * ONE, '0, 2));   // zero width
        send_line(make_seg(ONE, 0, 5 * ONE, ONE, 3 * ONE, 5 * ONE, 31'd1, 3)); // side rounds off
        send_line(make_seg(ONE, 0, 5 * ONE, ONE, 3 * ONE, 5 * ONE, 31'h7FFF_FFFF, 4));
        send_line(make_seg(SMAX, SMAX, SMAX, SMIN, SMIN, SMAX, 31'h7FFF_FFFF, 5));
        send_line(make_seg(SMIN, SMAX, SMIN, SMAX, SMIN, SMIN, 31'h4000_0000, 6));
        send_line(make_seg(SMIN, 0, SMAX, SMAX, 1, SMIN, 31'h7FFF_FFFF, 7));
        send_line(make_seg(SMAX, SMAX, 0, SMAX, SMAX, ONE, 31'h7FFF_FFFF, 8)); // wraps
        send_line(make_seg(3 * ONE, -ONE, 2 * ONE, -ONE, 4 * ONE, ONE, 31'(2 * ONE), 9));
        send_line(make_seg(0, 0, 10 * ONE, 1, 0, 10 * ONE, 31'(3 * ONE), 10)); // tiny direction
        send_line(make_seg(7, 3, 9, 7, 3, 8, 31'(ONE), 11));
        drain();

        // Eye somewhere random, moderate traffic with idling on both sides.
        place_eye(rand_coord(), rand_coord(), rand_coord());
        send_line(make_seg(ONE, ONE, ONE, 2 * ONE, ONE, 3 * ONE, 31'(ONE), 12));
        random_lines(110);

        // Sender waits for every vertex, then the eye goes to the extremes.
        drain();
        place_eye(SMIN, SMAX, SMIN);
        send_line(make_seg(SMIN, SMAX, SMIN + 1, SMIN, SMAX, SMIN, 31'(ONE), 13)); // B at the eye
        hold_request = 1;
        random_lines(120);
        drain();
        place_eye(SMAX, SMIN, SMAX);
        random_lines(50);
        drain();

        place_eye(rand_coord(), rand_coord(), rand_coord());
        random_lines(40);
        calm = 1;
        pause_sender(1);
        random_lines(70);
        pause_sender(1);
        while (!quads.empty()) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (quads.errors == 0 && quads.empty()) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
